// File: design/ray_sphere_intersect_macros.svh
// assertion macros used by the checker file
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ray sphere check failed");

// next-cycle implication, disabled during reset
`define RSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ray sphere check failed");

`endif

// File: design/rsi_pkg.sv
package rsi_pkg;

  // fraction bits of the direction format
  localparam int DIR_FRAC = 30;

  // datapath widths
  localparam int B_W    = 36;
  localparam int T_W    = 72;
  localparam int ROOT_W = 36;
  localparam int REM_W  = 40;

  // square root pipeline: bits of root resolved per stage
  localparam int SQRT_STEPS  = 4;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

  // register indexes
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_RADIUS_SQ = 2'd3;

  // side data carried along the square root pipeline
  typedef struct packed {
    logic signed [B_W-1:0] b;
    logic signed [31:0]    min_dist;
    logic signed [31:0]    max_dist;
    logic                  neg;
  } rsi_side_t;

endpackage

// File: design/rsi_sqrt_stage.sv
module rsi_sqrt_stage #(
  parameter int HI_BIT = 35,
  parameter int STEPS  = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  rsi_pkg::rsi_side_t        in_side,
  input  logic [rsi_pkg::T_W-1:0]   in_t,
  input  logic [rsi_pkg::REM_W-1:0] in_rem,
  input  logic [rsi_pkg::ROOT_W-1:0] in_root,
  output logic                      out_valid,
  output rsi_pkg::rsi_side_t        out_side,
  output logic [rsi_pkg::T_W-1:0]   out_t,
  output logic [rsi_pkg::REM_W-1:0] out_rem,
  output logic [rsi_pkg::ROOT_W-1:0] out_root
);
  import rsi_pkg::*;

  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  // restoring square root, two radicand bits per step
  always_comb begin
    logic [REM_W-1:0] trial;
    rem_nxt  = in_rem;
    root_nxt = in_root;
    trial    = '0;
    for (int j = 0; j < STEPS; j++) begin
      rem_nxt = {rem_nxt[REM_W-3:0], in_t[2*(HI_BIT-j)+1 -: 2]};
      trial   = {{(REM_W-ROOT_W-2){1'b0}}, root_nxt, 2'b01};
      if (rem_nxt >= trial) begin
        rem_nxt  = rem_nxt - trial;
        root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
      end else begin
        root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_side <= in_side;
    out_t    <= in_t;
    out_rem  <= rem_nxt;
    out_root <= root_nxt;
  end

endmodule

// File: design/ray_sphere_intersect.sv
// channel   | handshake            | payload
// request   | start / busy         | in_origin_*, in_dir_*, in_min_dist, in_max_dist
// result    | out_valid (strobe)   | out_hit, out_new_max_dist, out_*_so_far
// config    | psel/penable/pwrite  | paddr, pwdata, prdata (64-bit registers at 8*i)
//
// one request per cycle; busy is always low
// each result strobes out_valid once its request has passed stages 1 to 5, the
// square root stages, the sf register and the output register; results stay in order
// the square root pipeline has nine stages, four root bits a stage
// rst_n (synchronous) clears valid bits, tallies and configuration registers
// the receiver cannot stall; the pipeline never holds
module ray_sphere_intersect (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_origin_x,
  input  logic signed [30:0] in_origin_y,
  input  logic signed [30:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic signed [31:0] in_min_dist,
  input  logic signed [31:0] in_max_dist,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [31:0] out_new_max_dist,
  output logic [31:0]        out_tests_so_far,
  output logic [31:0]        out_hits_so_far,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import rsi_pkg::*;

  // configuration registers
  logic signed [30:0] center_x_r, center_y_r, center_z_r;
  logic [62:0]        radius_sq_r;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      center_z_r  <= '0;
      radius_sq_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTER_X:  center_x_r  <= pwdata[30:0];
        REG_CENTER_Y:  center_y_r  <= pwdata[30:0];
        REG_CENTER_Z:  center_z_r  <= pwdata[30:0];
        REG_RADIUS_SQ: radius_sq_r <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_CENTER_X:  prdata = {33'd0, center_x_r};
      REG_CENTER_Y:  prdata = {33'd0, center_y_r};
      REG_CENTER_Z:  prdata = {33'd0, center_z_r};
      REG_RADIUS_SQ: prdata = {1'b0, radius_sq_r};
      default:       prdata = '0;
    endcase
  end

  // stage 1: center minus origin
  logic               s1_valid_r;
  logic signed [31:0] s1_ax_r, s1_ay_r, s1_az_r;
  logic signed [31:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [31:0] s1_min_r, s1_max_r;

  always_ff @(posedge clk) begin
    s1_ax_r  <= {center_x_r[30], center_x_r} - {in_origin_x[30], in_origin_x};
    s1_ay_r  <= {center_y_r[30], center_y_r} - {in_origin_y[30], in_origin_y};
    s1_az_r  <= {center_z_r[30], center_z_r} - {in_origin_z[30], in_origin_z};
    s1_dx_r  <= in_dir_x;
    s1_dy_r  <= in_dir_y;
    s1_dz_r  <= in_dir_z;
    s1_min_r <= in_min_dist;
    s1_max_r <= in_max_dist;
  end

  // stage 2: products with the direction and squares
  logic               s2_valid_r;
  logic signed [63:0] s2_px_r, s2_py_r, s2_pz_r;
  logic signed [63:0] s2_qx_r, s2_qy_r, s2_qz_r;
  logic signed [31:0] s2_min_r, s2_max_r;

  always_ff @(posedge clk) begin
    s2_px_r  <= s1_ax_r * s1_dx_r;
    s2_py_r  <= s1_ay_r * s1_dy_r;
    s2_pz_r  <= s1_az_r * s1_dz_r;
    s2_qx_r  <= s1_ax_r * s1_ax_r;
    s2_qy_r  <= s1_ay_r * s1_ay_r;
    s2_qz_r  <= s1_az_r * s1_az_r;
    s2_min_r <= s1_min_r;
    s2_max_r <= s1_max_r;
  end

  // stage 3: b rounded down, and |adj|^2
  logic signed [65:0]  dot_sum;
  logic               s3_valid_r;
  logic signed [B_W-1:0] s3_b_r;
  logic [63:0]        s3_adj_sq_r;
  logic signed [31:0] s3_min_r, s3_max_r;

  assign dot_sum = {{2{s2_px_r[63]}}, s2_px_r} + {{2{s2_py_r[63]}}, s2_py_r}
                 + {{2{s2_pz_r[63]}}, s2_pz_r};

  always_ff @(posedge clk) begin
    s3_b_r      <= dot_sum[DIR_FRAC+B_W-1:DIR_FRAC];
    s3_adj_sq_r <= {1'b0, s2_qx_r[62:0]} + {1'b0, s2_qy_r[62:0]} + {1'b0, s2_qz_r[62:0]};
    s3_min_r    <= s2_min_r;
    s3_max_r    <= s2_max_r;
  end

  // stage 4: b squared
  logic [B_W-1:0]     b_mag;
  logic               s4_valid_r;
  logic [T_W-1:0]     s4_b2_r;
  logic signed [B_W-1:0] s4_b_r;
  logic [63:0]        s4_adj_sq_r;
  logic signed [31:0] s4_min_r, s4_max_r;

  assign b_mag = s3_b_r[B_W-1] ? B_W'(-s3_b_r) : B_W'(s3_b_r);

  always_ff @(posedge clk) begin
    s4_b2_r     <= b_mag * b_mag;
    s4_b_r      <= s3_b_r;
    s4_adj_sq_r <= s3_adj_sq_r;
    s4_min_r    <= s3_min_r;
    s4_max_r    <= s3_max_r;
  end

  // stage 5: discriminant
  logic [T_W-1:0]     disc_p;
  logic               s5_valid_r;
  logic [T_W-1:0]     s5_t_r;
  rsi_side_t          s5_side_r;

  assign disc_p = s4_b2_r + {9'd0, radius_sq_r};

  always_ff @(posedge clk) begin
    s5_t_r             <= disc_p - {8'd0, s4_adj_sq_r};
    s5_side_r.b        <= s4_b_r;
    s5_side_r.min_dist <= s4_min_r;
    s5_side_r.max_dist <= s4_max_r;
    s5_side_r.neg      <= disc_p < {8'd0, s4_adj_sq_r};
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  // square root pipeline
  logic              sq_valid [0:SQRT_STAGES];
  rsi_side_t         sq_side  [0:SQRT_STAGES];
  logic [T_W-1:0]    sq_t     [0:SQRT_STAGES];
  logic [REM_W-1:0]  sq_rem   [0:SQRT_STAGES];
  logic [ROOT_W-1:0] sq_root  [0:SQRT_STAGES];

  assign sq_valid[0] = s5_valid_r;
  assign sq_side[0]  = s5_side_r;
  assign sq_t[0]     = s5_t_r;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    rsi_sqrt_stage #(
      .HI_BIT(ROOT_W - 1 - SQRT_STEPS * k),
      .STEPS (SQRT_STEPS)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (sq_valid[k]),
      .in_side  (sq_side[k]),
      .in_t     (sq_t[k]),
      .in_rem   (sq_rem[k]),
      .in_root  (sq_root[k]),
      .out_valid(sq_valid[k+1]),
      .out_side (sq_side[k+1]),
      .out_t    (sq_t[k+1]),
      .out_rem  (sq_rem[k+1]),
      .out_root (sq_root[k+1])
    );
  end

  // root selection and interval test
  rsi_side_t          fs;
  logic signed [37:0] root_s, near_s, far_s, lo_s, hi_s;
  logic               hit_nxt;
  logic signed [31:0] new_max_nxt;

  assign fs     = sq_side[SQRT_STAGES];
  assign root_s = {2'b00, sq_root[SQRT_STAGES]};
  assign near_s = {{2{fs.b[B_W-1]}}, fs.b} - root_s;
  assign far_s  = {{2{fs.b[B_W-1]}}, fs.b} + root_s;
  assign lo_s   = {{6{fs.min_dist[31]}}, fs.min_dist};
  assign hi_s   = {{6{fs.max_dist[31]}}, fs.max_dist};

  always_comb begin
    hit_nxt     = 1'b0;
    new_max_nxt = fs.max_dist;
    if (!fs.neg) begin
      if (near_s > lo_s) begin
        hit_nxt = near_s < hi_s;
        if (hit_nxt) begin
          new_max_nxt = near_s[31:0];
        end
      end else begin
        hit_nxt = (far_s > lo_s) && (far_s < hi_s);
        if (hit_nxt) begin
          new_max_nxt = far_s[31:0];
        end
      end
    end
  end

  logic               sf_valid_r;
  logic               sf_hit_r;
  logic signed [31:0] sf_new_max_r;

  always_ff @(posedge clk) begin
    sf_hit_r     <= hit_nxt;
    sf_new_max_r <= new_max_nxt;
  end

  // output register and tallies
  logic               out_valid_r;
  logic               out_hit_r;
  logic signed [31:0] out_new_max_r;
  logic [31:0]        test_tally_r, hit_tally_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      test_tally_r <= '0;
      hit_tally_r  <= '0;
    end else begin
      sf_valid_r  <= sq_valid[SQRT_STAGES];
      out_valid_r <= sf_valid_r;
      if (sf_valid_r) begin
        test_tally_r <= test_tally_r + 32'd1;
        hit_tally_r  <= hit_tally_r + {31'd0, sf_hit_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r     <= sf_hit_r;
    out_new_max_r <= sf_new_max_r;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_new_max_dist = out_new_max_r;
  assign out_tests_so_far = test_tally_r;
  assign out_hits_so_far  = hit_tally_r;

endmodule

// File: design/rsi_checker.sv
`include "ray_sphere_intersect_macros.svh"

module rsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_max_dist,
  input logic        out_valid,
  input logic        out_hit,
  input logic [31:0] out_new_max_dist,
  input logic [31:0] out_tests_so_far,
  input logic [31:0] out_hits_so_far
);

  // every result follows a request taken a fixed latency earlier
  `RSI_ASSERT_NOW(a_result_has_request, clk, rst_n, out_valid, $past(start && !busy, 16))

  // a miss hands back the maximum of its own request
  `RSI_ASSERT_NOW(a_miss_keeps_max, clk, rst_n, out_valid && !out_hit, out_new_max_dist == $past(in_max_dist, 16))

  // test tally steps by one with each result
  `RSI_ASSERT_NOW(a_test_tally_step, clk, rst_n, out_valid, out_tests_so_far == $past(out_tests_so_far) + 32'd1)

  // hit tally follows the hit flag
  `RSI_ASSERT_NOW(a_hit_tally_step, clk, rst_n, out_valid, out_hits_so_far == $past(out_hits_so_far) + {31'd0, out_hit})

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
